// ===== hdl/ssq_pkg.sv =====
package ssq_pkg;

  localparam int CNT_W = 31;
  localparam int ID_W = 8;
  localparam int TICKS_W = 32;
  localparam int KIND_W = 3;
  localparam int TCNT_W = 63;
  localparam int MAX_RESULTS = 16;
  localparam int WAKE_W = $clog2(MAX_RESULTS);

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_QUEUED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_YIELD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WOKEN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOWAKE = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_DEC = 2'd1,
    OP_INS = 2'd2,
    OP_POP = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [CNT_W-1:0] key;
    logic [ID_W-1:0] id;
  } cell_ctrl_t;

endpackage

// ===== hdl/ssq_cell.sv =====
module ssq_cell
  import ssq_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             occupied,
  input  logic             le_prev,
  input  logic [CNT_W-1:0] left_cnt,
  input  logic [ID_W-1:0]  left_id,
  input  logic [CNT_W-1:0] right_cnt,
  input  logic [ID_W-1:0]  right_id,
  output logic [CNT_W-1:0] cnt,
  output logic [ID_W-1:0]  id,
  output logic             le
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  // The queue is sorted, so the cells whose count is not above the key form a prefix.
  assign le = occupied && (cnt_r <= ctrl.key);

  always_comb begin
    cnt_nxt = cnt_r;
    id_nxt = id_r;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_DEC: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_INS: begin
        if (!le) begin
          if (le_prev) begin
            cnt_nxt = ctrl.key;
            id_nxt = ctrl.id;
          end else begin
            cnt_nxt = left_cnt;
            id_nxt = left_id;
          end
        end
      end
      OP_POP: begin
        cnt_nxt = right_cnt;
        id_nxt = right_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    id_r <= id_nxt;
  end

  assign cnt = cnt_r;
  assign id = id_r;

endmodule

// ===== hdl/sorted_sleep_timer_queue_unit.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_cmd, in_sleeper_id, in_sleep_ticks
// out     | out_valid / out_ready| out_kind, out_woken_id, out_tick_count, out_last
//
// A sleep request is captured, then inserted into the cell row unless it yields or the queue is full.
// A tick is captured, then decrements every cell, then pops one front entry out of the cell row
// per woken result (at most 16), or gives a single no-wake result if nothing wakes.
// The output register lets a new item be captured while the last result still waits.
// Reset (rst_n low, synchronous) empties the queue and clears the tick counter.
// A stalled output freezes the cell row until the result is taken, except for a tick's decrement.
module sorted_sleep_timer_queue_unit
  import ssq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [ID_W-1:0]           in_sleeper_id,
  input  logic signed [TICKS_W-1:0] in_sleep_ticks,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [KIND_W-1:0]         out_kind,
  output logic [ID_W-1:0]           out_woken_id,
  output logic [TCNT_W-1:0]         out_tick_count,
  output logic                      out_last
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAKE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [TICKS_W-1:0] ticks_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [TCNT_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic [WAKE_W-1:0]  wake_cnt_r, wake_cnt_nxt;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r, kind_nxt;
  logic [ID_W-1:0]    out_id_r, oid_nxt;
  logic [TCNT_W-1:0]  out_tick_r;
  logic               out_last_r, last_nxt;
  logic               load_out;
  logic               out_free;
  logic               front_wake;

  cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]   cnt_w [QUEUE_DEPTH];
  logic [ID_W-1:0]    id_w [QUEUE_DEPTH];
  logic               le_w [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [CNT_W-1:0] l_cnt, r_cnt;
    logic [ID_W-1:0]  l_id, r_id;
    logic             l_le;
    if (i == 0) begin : g_head
      assign l_cnt = ctrl.key;
      assign l_id = ctrl.id;
      assign l_le = 1'b1;
    end else begin : g_body
      assign l_cnt = cnt_w[i-1];
      assign l_id = id_w[i-1];
      assign l_le = le_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_cnt = cnt_w[i];
      assign r_id = id_w[i];
    end else begin : g_mid
      assign r_cnt = cnt_w[i+1];
      assign r_id = id_w[i+1];
    end
    ssq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (OCC_W'(i) < occ_r),
      .le_prev   (l_le),
      .left_cnt  (l_cnt),
      .left_id   (l_id),
      .right_cnt (r_cnt),
      .right_id  (r_id),
      .cnt       (cnt_w[i]),
      .id        (id_w[i]),
      .le        (le_w[i])
    );
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign front_wake = (occ_r != '0) && (cnt_w[0] == '0);

  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r;
    tick_cnt_nxt = tick_cnt_r;
    wake_cnt_nxt = wake_cnt_r;
    ctrl.op = OP_HOLD;
    ctrl.key = ticks_r[CNT_W-1:0];
    ctrl.id = id_r;
    load_out = 1'b0;
    kind_nxt = KIND_QUEUED;
    oid_nxt = id_r;
    last_nxt = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_TICK) begin
          ctrl.op = OP_DEC;
          tick_cnt_nxt = tick_cnt_r + 1'b1;
          wake_cnt_nxt = '0;
          state_nxt = ST_WAKE;
        end else if (out_free) begin
          load_out = 1'b1;
          state_nxt = ST_IDLE;
          if (ticks_r[TICKS_W-1]) begin
            kind_nxt = KIND_YIELD;
          end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
            kind_nxt = KIND_FULL;
          end else begin
            kind_nxt = KIND_QUEUED;
            ctrl.op = OP_INS;
            occ_nxt = occ_r + 1'b1;
          end
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          load_out = 1'b1;
          if (front_wake) begin
            kind_nxt = KIND_WOKEN;
            oid_nxt = id_w[0];
            ctrl.op = OP_POP;
            occ_nxt = occ_r - 1'b1;
            wake_cnt_nxt = wake_cnt_r + 1'b1;
            // Stop when the queue drains, the next entry is still sleeping,
            // or this tick has used up its result budget.
            last_nxt = (occ_r == OCC_W'(1)) || (cnt_w[1] != '0) ||
                       (wake_cnt_r == WAKE_W'(MAX_RESULTS - 1));
          end else begin
            kind_nxt = KIND_NOWAKE;
            oid_nxt = '0;
            last_nxt = 1'b1;
          end
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r <= '0;
      tick_cnt_r <= '0;
      wake_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      wake_cnt_r <= wake_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      id_r <= in_sleeper_id;
      ticks_r <= in_sleep_ticks;
    end
    if (load_out) begin
      out_kind_r <= kind_nxt;
      out_id_r <= oid_nxt;
      out_tick_r <= tick_cnt_r;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_woken_id = out_id_r;
  assign out_tick_count = out_tick_r;
  assign out_last = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_wake_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAKE && out_free && front_wake) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("woken entry not removed from queue");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && cmd_r == CMD_TICK) |=> (tick_cnt_r == $past(tick_cnt_r) + 1'b1))
    else $error("tick counter did not advance on tick");

  a_no_wake_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && kind_nxt == KIND_WOKEN) |-> (occ_r != '0))
    else $error("wake issued from empty queue");

endmodule
